>>> hdl/gamepad_report_to_joystick_latch_macros.svh
// Assertion macros for the gamepad report to joystick latch.
// Included by the top level; expects signals named clk and rst in scope.
`ifndef GAMEPAD_REPORT_TO_JOYSTICK_LATCH_MACROS_SVH
`define GAMEPAD_REPORT_TO_JOYSTICK_LATCH_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define GPJL_ASSERT_IMP(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("gpjl assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define GPJL_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("gpjl assertion failed");

`endif

>>> hdl/gpjl_pkg.sv
// Shared types and constants for the gamepad report to joystick latch.
// No dependencies; used by gpjl_decode and the top level.
`default_nettype none
package gpjl_pkg;

  localparam int NUM_PORTS = 2;
  localparam int IDX_W     = 1;

  // Command codes.
  localparam logic CMD_DECODE = 1'b0;
  localparam logic CMD_RAW    = 1'b1;

  // Active-low joystick bits.
  localparam logic [7:0] K_UP    = 8'h01;
  localparam logic [7:0] K_RIGHT = 8'h02;
  localparam logic [7:0] K_DOWN  = 8'h04;
  localparam logic [7:0] K_LEFT  = 8'h08;
  localparam logic [7:0] K_FIRE  = 8'h40;

  // Keypad codes and masks.
  localparam logic [7:0] KEY_MASK   = 8'hf0;
  localparam logic [7:0] KEY_START1 = 8'h02;
  localparam logic [7:0] KEY_START2 = 8'h08;
  localparam logic [7:0] FACE_MASK  = 8'h60;

  // Stick thresholds.
  localparam logic [7:0] STICK_LO = 8'h40;
  localparam logic [7:0] STICK_HI = 8'hc0;

  localparam logic [15:0] MIN_REPORT_LEN = 16'd6;
  localparam logic [7:0]  IDLE_RESET     = 8'hff;

  // Hat codes that name a direction; codes 8 to 15 are neutral.
  localparam logic [3:0] HAT_UP         = 4'd0;
  localparam logic [3:0] HAT_UP_RIGHT   = 4'd1;
  localparam logic [3:0] HAT_RIGHT      = 4'd2;
  localparam logic [3:0] HAT_RIGHT_DOWN = 4'd3;
  localparam logic [3:0] HAT_DOWN       = 4'd4;
  localparam logic [3:0] HAT_DOWN_LEFT  = 4'd5;
  localparam logic [3:0] HAT_LEFT       = 4'd6;
  localparam logic [3:0] HAT_LEFT_UP    = 4'd7;

  // Register byte address decode.
  localparam logic [2:0] ADDR_IDLE_VALUE = 3'd0;

  // Stage-one record handed to the compare and update stage.
  typedef struct packed {
    logic             port_ok;
    logic             len_ok;
    logic [IDX_W-1:0] idx;
    logic [7:0]       value;
  } s1_t;

endpackage
`default_nettype wire

>>> hdl/gamepad_report_to_joystick_latch.sv
// Gamepad report to joystick latch, top level. Takes one beat per cycle while the result
// channel does not stall it; stage one decodes, stage two compares with and updates
// the stored port byte and loads the result register.
// Reset: synchronous; both port bytes and idle_value return to 0xff, pipeline empties.
// Depends on gpjl_pkg, gpjl_decode and gamepad_report_to_joystick_latch_macros.svh.
`default_nettype none
`include "gamepad_report_to_joystick_latch_macros.svh"
module gamepad_report_to_joystick_latch (
  input  wire logic        clk,
  input  wire logic        rst,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // Input channel.
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [7:0]  port,
  input  wire logic [7:0]  stick_x,
  input  wire logic [7:0]  stick_y,
  input  wire logic [7:0]  buttons_a,
  input  wire logic [7:0]  buttons_b,
  input  wire logic [15:0] report_length,
  input  wire logic [7:0]  raw_value,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             accepted,
  output logic             frame_valid,
  output logic      [23:0] frame,
  output logic      [7:0]  port_value
);

  logic [7:0]          idle_value;
  logic [7:0]          decoded;
  logic                s1_valid;
  gpjl_pkg::s1_t       s1;
  gpjl_pkg::s1_t       s1_next;
  logic                advance;
  logic [7:0]          port_bytes [gpjl_pkg::NUM_PORTS];
  logic [7:0]          cur;
  logic                update;
  logic [7:0]          pb0_next;
  logic [7:0]          pb1_next;
  logic                wr_idle;

  // Configuration register.
  assign pready  = 1'b1;
  assign wr_idle = psel & penable & pwrite & pready & (paddr[2] == gpjl_pkg::ADDR_IDLE_VALUE[2]);
  assign prdata  = (paddr[2] == gpjl_pkg::ADDR_IDLE_VALUE[2]) ? {24'h0, idle_value} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_value <= gpjl_pkg::IDLE_RESET;
    end else if (wr_idle) begin
      idle_value <= pwdata[7:0];
    end
  end

  // Handshake: stage two moves when the result register is free or being taken.
  assign advance  = s1_valid & (~out_valid | out_ready);
  assign in_ready = ~s1_valid | advance;

  gpjl_decode u_decode (
    .idle_value (idle_value),
    .stick_x    (stick_x),
    .stick_y    (stick_y),
    .buttons_a  (buttons_a),
    .buttons_b  (buttons_b),
    .value      (decoded)
  );

  // Stage one: port check, length check and the candidate byte.
  always_comb begin
    s1_next.port_ok = ({24'h0, port} < gpjl_pkg::NUM_PORTS);
    s1_next.len_ok  = (cmd == gpjl_pkg::CMD_RAW) | (report_length >= gpjl_pkg::MIN_REPORT_LEN);
    s1_next.idx     = port[gpjl_pkg::IDX_W-1:0];
    s1_next.value   = (cmd == gpjl_pkg::CMD_RAW) ? raw_value : decoded;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready & in_valid) begin
      s1 <= s1_next;
    end
  end

  // Stage two: compare with the stored byte and form the new frame.
  assign cur      = port_bytes[s1.idx];
  assign update   = s1.port_ok & s1.len_ok & (cur != s1.value);
  assign pb0_next = (update & (s1.idx == 1'b0)) ? s1.value : port_bytes[0];
  assign pb1_next = (update & (s1.idx == 1'b1)) ? s1.value : port_bytes[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      port_bytes[0] <= gpjl_pkg::IDLE_RESET;
      port_bytes[1] <= gpjl_pkg::IDLE_RESET;
      out_valid     <= 1'b0;
    end else begin
      if (advance) begin
        port_bytes[0] <= pb0_next;
        port_bytes[1] <= pb1_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid     <= 1'b0;
      end
    end
    if (advance) begin
      accepted    <= s1.port_ok & s1.len_ok;
      frame_valid <= update;
      frame       <= update ? {7'h00, pb0_next, pb1_next, 1'b0} : 24'h0;
      if (!s1.port_ok) begin
        port_value <= idle_value;
      end else if (update) begin
        port_value <= s1.value;
      end else begin
        port_value <= cur;
      end
    end
  end

  // A frame is only sent for an accepted beat.
  `GPJL_ASSERT_IMP(a_frame_needs_accept, out_valid & frame_valid, accepted)
  // A sent frame mirrors the stored port bytes while the result waits.
  `GPJL_ASSERT_IMP(a_frame_matches_state, out_valid & frame_valid,
    (frame[16:9] == port_bytes[0]) && (frame[8:1] == port_bytes[1]))
  // Without a change no frame bits are set.
  `GPJL_ASSERT_IMP(a_quiet_frame_zero, out_valid & ~frame_valid, frame == 24'h0)
  // Stored bytes only change when stage two moves.
  `GPJL_ASSERT_NEXT(a_state_held, ~advance,
    $stable(port_bytes[0]) && $stable(port_bytes[1]))

endmodule
`default_nettype wire

>>> hdl/gpjl_decode.sv
// Report decoder: turns one gamepad report into an active-low port byte.
// Depends on gpjl_pkg for bit masks, thresholds and hat codes.
`default_nettype none
module gpjl_decode (
  input  wire logic [7:0] idle_value,
  input  wire logic [7:0] stick_x,
  input  wire logic [7:0] stick_y,
  input  wire logic [7:0] buttons_a,
  input  wire logic [7:0] buttons_b,
  output logic      [7:0] value
);

  logic       start1;
  logic       start2;
  logic [7:0] clr;
  logic [7:0] base;

  assign start1 = buttons_b[4] | buttons_a[4];
  assign start2 = buttons_b[5] | buttons_a[7];

  // Hat directions, with the left stick as fallback when the hat is neutral.
  always_comb begin
    clr = 8'h00;
    case (buttons_a[3:0])
      gpjl_pkg::HAT_UP:         clr = gpjl_pkg::K_UP;
      gpjl_pkg::HAT_UP_RIGHT:   clr = gpjl_pkg::K_UP | gpjl_pkg::K_RIGHT;
      gpjl_pkg::HAT_RIGHT:      clr = gpjl_pkg::K_RIGHT;
      gpjl_pkg::HAT_RIGHT_DOWN: clr = gpjl_pkg::K_RIGHT | gpjl_pkg::K_DOWN;
      gpjl_pkg::HAT_DOWN:       clr = gpjl_pkg::K_DOWN;
      gpjl_pkg::HAT_DOWN_LEFT:  clr = gpjl_pkg::K_DOWN | gpjl_pkg::K_LEFT;
      gpjl_pkg::HAT_LEFT:       clr = gpjl_pkg::K_LEFT;
      gpjl_pkg::HAT_LEFT_UP:    clr = gpjl_pkg::K_LEFT | gpjl_pkg::K_UP;
      default: begin
        if (stick_x < gpjl_pkg::STICK_LO) clr = clr | gpjl_pkg::K_LEFT;
        if (stick_x > gpjl_pkg::STICK_HI) clr = clr | gpjl_pkg::K_RIGHT;
        if (stick_y < gpjl_pkg::STICK_LO) clr = clr | gpjl_pkg::K_UP;
        if (stick_y > gpjl_pkg::STICK_HI) clr = clr | gpjl_pkg::K_DOWN;
      end
    endcase
  end

  // Start keys override the directions with a keypad code.
  always_comb begin
    if (start1) begin
      base = (idle_value & gpjl_pkg::KEY_MASK) | gpjl_pkg::KEY_START1;
    end else if (start2) begin
      base = (idle_value & gpjl_pkg::KEY_MASK) | gpjl_pkg::KEY_START2;
    end else begin
      base = idle_value & ~clr;
    end
  end

  // Either face button pulls fire low.
  assign value = ((buttons_a & gpjl_pkg::FACE_MASK) != 8'h00) ?
                 (base & ~gpjl_pkg::K_FIRE) : base;

endmodule
`default_nettype wire

>>> verif/gamepad_report_to_joystick_latch_tb.sv
// Testbench for the gamepad report to joystick latch: directed and random report beats,
// checked beat by beat against an in-bench predictor of the two latched port bytes.
// Depends on gpjl_pkg and the gamepad_report_to_joystick_latch top level.
`timescale 1ns / 100ps
module gamepad_report_to_joystick_latch_tb;

  // Report bits that the predictor decodes.
  localparam logic [7:0] START1_A = 8'h10;
  localparam logic [7:0] START2_A = 8'h80;
  localparam logic [7:0] START1_B = 8'h10;
  localparam logic [7:0] START2_B = 8'h20;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  port;
    logic [7:0]  stick_x;
    logic [7:0]  stick_y;
    logic [7:0]  buttons_a;
    logic [7:0]  buttons_b;
    logic [15:0] report_length;
    logic [7:0]  raw_value;
  } report_beat_t;

  typedef struct packed {
    logic        accepted;
    logic        frame_valid;
    logic [23:0] frame;
    logic [7:0]  port_value;
  } joystick_result_t;

  // Predicts the latched port bytes and holds the results still to come.
  class joystick_scoreboard;
    logic [7:0]       idle_byte;
    logic [7:0]       latched [gpjl_pkg::NUM_PORTS];
    joystick_result_t expected_results[$];
    int unsigned      failures;

    function new();
      idle_byte = gpjl_pkg::IDLE_RESET;
      foreach (latched[i]) latched[i] = gpjl_pkg::IDLE_RESET;
      failures = 0;
    endfunction

    function void set_idle(logic [7:0] value);
      idle_byte = value;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Turns one report into the active-low joystick byte.
    function logic [7:0] decode_report(report_beat_t b);
      logic [7:0] v;
      logic [7:0] clr;
      v = idle_byte;
      clr = '0;
      if ((b.buttons_b & START1_B) != 0 || (b.buttons_a & START1_A) != 0) begin
        v = (v & gpjl_pkg::KEY_MASK) | gpjl_pkg::KEY_START1;
      end else if ((b.buttons_b & START2_B) != 0 || (b.buttons_a & START2_A) != 0) begin
        v = (v & gpjl_pkg::KEY_MASK) | gpjl_pkg::KEY_START2;
      end else begin
        case (b.buttons_a[3:0])
          gpjl_pkg::HAT_UP:         clr = gpjl_pkg::K_UP;
          gpjl_pkg::HAT_UP_RIGHT:   clr = gpjl_pkg::K_UP | gpjl_pkg::K_RIGHT;
          gpjl_pkg::HAT_RIGHT:      clr = gpjl_pkg::K_RIGHT;
          gpjl_pkg::HAT_RIGHT_DOWN: clr = gpjl_pkg::K_RIGHT | gpjl_pkg::K_DOWN;
          gpjl_pkg::HAT_DOWN:       clr = gpjl_pkg::K_DOWN;
          gpjl_pkg::HAT_DOWN_LEFT:  clr = gpjl_pkg::K_DOWN | gpjl_pkg::K_LEFT;
          gpjl_pkg::HAT_LEFT:       clr = gpjl_pkg::K_LEFT;
          gpjl_pkg::HAT_LEFT_UP:    clr = gpjl_pkg::K_LEFT | gpjl_pkg::K_UP;
          default: begin
            // Neutral hat: the left stick decides.
            if (b.stick_x < gpjl_pkg::STICK_LO) clr = clr | gpjl_pkg::K_LEFT;
            if (b.stick_x > gpjl_pkg::STICK_HI) clr = clr | gpjl_pkg::K_RIGHT;
            if (b.stick_y < gpjl_pkg::STICK_LO) clr = clr | gpjl_pkg::K_UP;
            if (b.stick_y > gpjl_pkg::STICK_HI) clr = clr | gpjl_pkg::K_DOWN;
          end
        endcase
        v = v & ~clr;
      end
      if ((b.buttons_a & gpjl_pkg::FACE_MASK) != 0) v = v & ~gpjl_pkg::K_FIRE;
      return v;
    endfunction

    // Notes an accepted input beat and queues the result it causes.
    function void note_beat(report_beat_t b);
      joystick_result_t r;
      logic [7:0]       v;
      int               idx;
      r = '0;
      idx = int'(b.port);
      if (b.port >= gpjl_pkg::NUM_PORTS) begin
        r.port_value = idle_byte;
      end else if (b.cmd == gpjl_pkg::CMD_DECODE &&
                   b.report_length < gpjl_pkg::MIN_REPORT_LEN) begin
        r.port_value = latched[idx];
      end else begin
        v = (b.cmd == gpjl_pkg::CMD_RAW) ? b.raw_value : decode_report(b);
        r.accepted = 1'b1;
        if (latched[idx] != v) begin
          latched[idx] = v;
          r.frame_valid = 1'b1;
          r.frame = {7'b0, latched[0], latched[1], 1'b0};
        end
        r.port_value = latched[idx];
      end
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [23:0] want, logic [23:0] got);
      if (want !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        failures++;
      end
    endfunction

    // Checks a result beat against the oldest expectation.
    function void check_beat(joystick_result_t got);
      joystick_result_t want;
      if (expected_results.size() == 0) begin
        $error("result beat arrived with no result expected");
        failures++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("accepted", 24'(want.accepted), 24'(got.accepted));
      compare_field("frame_valid", 24'(want.frame_valid), 24'(got.frame_valid));
      compare_field("frame", want.frame, got.frame);
      compare_field("port_value", 24'(want.port_value), 24'(got.port_value));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        cmd = 1'b0;
  logic [7:0]  port = '0;
  logic [7:0]  stick_x = '0;
  logic [7:0]  stick_y = '0;
  logic [7:0]  buttons_a = '0;
  logic [7:0]  buttons_b = '0;
  logic [15:0] report_length = '0;
  logic [7:0]  raw_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        accepted;
  logic        frame_valid;
  logic [23:0] frame;
  logic [7:0]  port_value;

  // Random idling on each side, switched off for one long stretch.
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  joystick_scoreboard sb;

  gamepad_report_to_joystick_latch dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready),
    .cmd(cmd), .port(port), .stick_x(stick_x), .stick_y(stick_y),
    .buttons_a(buttons_a), .buttons_b(buttons_b),
    .report_length(report_length), .raw_value(raw_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .accepted(accepted), .frame_valid(frame_valid), .frame(frame),
    .port_value(port_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side back-pressure, changed on the falling edge.
  always @(negedge clk) begin
    out_ready <= rx_idle ? ($urandom_range(99) >= 36) : 1'b1;
  end

  // Watch both channels on the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        sb.check_beat({accepted, frame_valid, frame, port_value});
      end
      if (in_valid && in_ready) begin
        sb.note_beat({cmd, port, stick_x, stick_y, buttons_a, buttons_b,
                      report_length, raw_value});
      end
    end
  end

  // Sends one input beat; called and returns on a falling edge.
  task automatic send_beat(report_beat_t b);
    while (tx_idle && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    cmd           <= b.cmd;
    port          <= b.port;
    stick_x       <= b.stick_x;
    stick_y       <= b.stick_y;
    buttons_a     <= b.buttons_a;
    buttons_b     <= b.buttons_b;
    report_length <= b.report_length;
    raw_value     <= b.raw_value;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_fields(logic c, logic [7:0] p, logic [7:0] sx, logic [7:0] sy,
                             logic [7:0] ba, logic [7:0] bb, logic [15:0] len,
                             logic [7:0] raw);
    send_beat({c, p, sx, sy, ba, bb, len, raw});
  endtask

  // Holds the sender off until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  // Two-phase register write of the idle byte.
  task automatic write_idle(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= gpjl_pkg::ADDR_IDLE_VALUE;
    pwdata  <= {24'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_idle(value);
  endtask

  // Stick values cluster on the thresholds.
  function automatic logic [7:0] pick_stick();
    case ($urandom_range(7))
      0: return 8'h3f;
      1: return gpjl_pkg::STICK_LO;
      2: return gpjl_pkg::STICK_HI;
      3: return 8'hc1;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed reports for valid ports, with some noise.
  function automatic report_beat_t make_random_report();
    report_beat_t b;
    int           pick;
    b.cmd = ($urandom_range(99) < 30) ? gpjl_pkg::CMD_RAW : gpjl_pkg::CMD_DECODE;
    if ($urandom_range(99) < 88) b.port = 8'($urandom_range(gpjl_pkg::NUM_PORTS - 1, 0));
    else b.port = 8'($urandom_range(255, gpjl_pkg::NUM_PORTS));
    pick = $urandom_range(99);
    if (pick < 8) b.report_length = 16'($urandom_range(5, 0));
    else if (pick < 13) b.report_length = 16'($urandom);
    else b.report_length = 16'($urandom_range(64, 6));
    b.stick_x = pick_stick();
    b.stick_y = pick_stick();
    if ($urandom_range(99) < 5) begin
      b.buttons_a = 8'($urandom);
      b.buttons_b = 8'($urandom);
    end else begin
      b.buttons_a = {$urandom_range(99) < 10, 2'($urandom), $urandom_range(99) < 10,
                     4'($urandom)};
      b.buttons_b = 8'($urandom);
      b.buttons_b[4] = $urandom_range(99) < 10;
      b.buttons_b[5] = $urandom_range(99) < 10;
    end
    b.raw_value = 8'($urandom);
    return b;
  endfunction

  initial begin
    logic [7:0] idle_plan [6];
    sb = new();
    idle_plan = '{8'h00, 8'hff, 8'($urandom), 8'h0f, 8'hf0, 8'($urandom)};
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed beats under the reset idle byte.
    send_fields(gpjl_pkg::CMD_RAW, 8'd0, 8'h80, 8'h80, 8'h08, 8'h00, 16'd6, 8'h00);
    send_fields(gpjl_pkg::CMD_RAW, 8'd0, 8'h80, 8'h80, 8'h08, 8'h00, 16'd6, 8'h00);
    send_fields(gpjl_pkg::CMD_RAW, 8'd1, 8'h80, 8'h80, 8'h08, 8'h00, 16'd0, 8'ha5);
    send_fields(gpjl_pkg::CMD_RAW, 8'd2, 8'h80, 8'h80, 8'h08, 8'h00, 16'd6, 8'h12);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd255, 8'h00, 8'hff, 8'h00, 8'h00, 16'hffff, 8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd0, 8'h80, 8'h80, 8'h08, 8'h00, 16'd0, 8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd1, 8'h80, 8'h80, 8'h08, 8'h00, 16'd5, 8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd0, 8'h80, 8'h80, 8'h08, 8'h00, 16'd6, 8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd1, 8'h80, 8'h80, 8'h08, START1_B, 16'hffff, 8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd1, 8'h80, 8'h80, START1_A | 8'h20, 8'h00, 16'd6,
                8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd0, 8'h80, 8'h80, 8'h08, START2_B, 16'd6, 8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd0, 8'h80, 8'h80, START2_A | 8'h40, 8'h00, 16'd6,
                8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd1, 8'h80, 8'h80, 8'h08, START1_B | START2_B, 16'd6,
                8'h00);
    for (int h = 0; h < 8; h++) begin
      send_fields(gpjl_pkg::CMD_DECODE, 8'(h % 2), 8'h80, 8'h80, 8'(h), 8'h00, 16'd6, 8'h00);
    end
    send_fields(gpjl_pkg::CMD_DECODE, 8'd0, 8'h00, 8'hff, 8'h0f, 8'h00, 16'd6, 8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd0, gpjl_pkg::STICK_LO, gpjl_pkg::STICK_HI, 8'h08,
                8'h00, 16'd6, 8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd1, 8'hc1, 8'h3f, 8'h09, 8'h00, 16'd6, 8'h00);
    send_fields(gpjl_pkg::CMD_DECODE, 8'd1, 8'hff, 8'h00, 8'h08 | gpjl_pkg::FACE_MASK, 8'h00,
                16'd6, 8'h00);
    drain();

    // Random phases, each under its own idle byte; the third runs with no idling.
    for (int ph = 0; ph < 6; ph++) begin
      write_idle(idle_plan[ph]);
      tx_idle = (ph != 2);
      rx_idle = (ph != 2);
      for (int n = 0; n < 300; n++) begin
        if (ph == 0 && n == 150) drain();
        send_beat(make_random_report());
      end
      drain();
    end

    repeat (10) @(posedge clk);
    if (sb.failures == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end

endmodule
